### rtl/trm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the register machine core.
// ----------------------------------------------------------------------------
package trm_pkg;

    localparam int NumRegs = 5;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_DONE     = 3'd0,
        STS_EXECUTED = 3'd1,
        STS_NOT_RUN  = 3'd2,
        STS_HALTED   = 3'd3,
        STS_DIV_ZERO = 3'd4,
        STS_BAD_OP   = 3'd5,
        STS_PC_RANGE = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_RDCAP, ST_FETCH, ST_FCAP,
        ST_RDA, ST_RDB, ST_EXEC, ST_ALU, ST_WB, ST_DIV, ST_DONE
    } t_state;

    localparam logic [31:0] OP_LDI  = 32'd0;
    localparam logic [31:0] OP_ST   = 32'd1;
    localparam logic [31:0] OP_ADD  = 32'd2;
    localparam logic [31:0] OP_SUB  = 32'd3;
    localparam logic [31:0] OP_MUL  = 32'd4;
    localparam logic [31:0] OP_DIV  = 32'd5;
    localparam logic [31:0] OP_JMP  = 32'd6;
    localparam logic [31:0] OP_JEQ  = 32'd7;
    localparam logic [31:0] OP_JNE  = 32'd8;
    localparam logic [31:0] OP_CMP  = 32'd9;
    localparam logic [31:0] OP_PRT  = 32'd10;
    localparam logic [31:0] OP_HALT = 32'd11;

    localparam logic [31:0] CarryHi = 32'd65535;
    localparam logic [31:0] CarryLo = 32'hFFFF_8000;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    function automatic logic [2:0] reg_index(input logic [31:0] code);
        reg_index = (code < 32'(NumRegs)) ? code[2:0] : 3'd0;
    endfunction

endpackage

### rtl/trm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_in_if / trm_out_if
// Valid/ready channels carrying commands in and results out.
// ----------------------------------------------------------------------------
interface trm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [9:0]         address;
    logic signed [31:0] data;
    logic [2:0]         reg_select;
    modport source (output valid, command, address, data, reg_select, input ready);
    modport sink   (input valid, command, address, data, reg_select, output ready);
endinterface

interface trm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] opcode;
    logic signed [31:0] prog_counter;
    logic               is_running;
    logic               zero_flag;
    logic               carry_flag;
    logic signed [31:0] value;
    logic signed [31:0] reg_value;
    modport source (output valid, status, opcode, prog_counter, is_running, zero_flag,
                    carry_flag, value, reg_value, input ready);
    modport sink   (input valid, status, opcode, prog_counter, is_running, zero_flag,
                    carry_flag, value, reg_value, output ready);
endinterface

### rtl/toy_register_machine_core_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_register_machine_core_top
// Multi-cycle toy machine: word memory, five registers, PC and flags.
// ----------------------------------------------------------------------------
// One command is taken at a time; ready stays low until its result is out.
// After reset the word memory is cleared, one word a cycle, before the first
// command is taken. A write or start passes from IDLE through DONE; a read
// also makes one registered memory read (READ, RDCAP). A step fetches four
// words through the single memory read port (FETCH, FCAP), reads its two
// register operands (RDA, RDB), then executes; add/sub/mul/compare go on
// through ALU and WB, and a divide waits in DIV for the one-bit-per-cycle
// divider before WB.
module toy_register_machine_core_top #(
    parameter int MEM_WORDS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trm_in_if.sink     i_cmd,
    trm_out_if.source  o_res
);
    import trm_pkg::*;

    localparam int          AW      = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LastIdx = AW'(MEM_WORDS - 1);
    localparam logic [31:0] MemSize = 32'(MEM_WORDS);

    // word memory, single write port, registered read
    logic [31:0]   mem [MEM_WORDS];
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;
    logic [31:0]   r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // sequencer state
    t_state       r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_cmd         r_cmd, n_cmd;
    logic [31:0]  r_addr, n_addr;
    logic [31:0]  r_data, n_data;
    logic [2:0]   r_sel, n_sel;
    logic [31:0]  r_pc, n_pc;
    logic         r_run, n_run, r_zf, n_zf, r_cf, n_cf;
    logic [31:0]  r_rf [NumRegs];
    logic [31:0]  n_rf [NumRegs];
    logic [31:0]  r_ops [4];
    logic [31:0]  n_ops [4];
    logic [1:0]   r_k, n_k;
    logic [31:0]  r_a, n_a, r_b, n_b, r_res, n_res;
    t_status      r_status, n_status;
    logic [31:0]  r_opw, n_opw, r_val, n_val, r_rval, n_rval;
    logic         r_out_valid, n_out_valid;
    logic [2:0]   r_o_status, n_o_status;
    logic [31:0]  r_o_opw, n_o_opw, r_o_pc, n_o_pc, r_o_val, n_o_val, r_o_rval, n_o_rval;
    logic         r_o_run, n_o_run, r_o_zf, n_o_zf, r_o_cf, n_o_cf;

    logic         accept;
    logic [2:0]   rf_idx;
    logic [31:0]  rf_rd;
    logic [31:0]  fetch_addr;
    logic [2:0]   r1, r2;
    logic [31:0]  alu_out;
    t_div_req     div_req;
    logic         div_done;
    logic [31:0]  div_q;

    trm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign i_cmd.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign fetch_addr  = r_pc + 32'(r_k);
    assign r1          = reg_index(r_ops[1]);
    assign r2          = reg_index(r_ops[2]);
    assign rf_rd       = r_rf[rf_idx];

    // shared add/sub/mul unit, result registered before flags
    always_comb begin
        case (r_ops[0])
            OP_ADD:  alu_out = r_a + r_b;
            OP_MUL:  alu_out = r_a * r_b;
            default: alu_out = r_a - r_b;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_data   = r_data;
        n_sel    = r_sel;
        n_pc     = r_pc;
        n_run    = r_run;
        n_zf     = r_zf;
        n_cf     = r_cf;
        n_rf     = r_rf;
        n_ops    = r_ops;
        n_k      = r_k;
        n_a      = r_a;
        n_b      = r_b;
        n_res    = r_res;
        n_status = r_status;
        n_opw    = r_opw;
        n_val    = r_val;
        n_rval   = r_rval;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_status = r_o_status;
        n_o_opw  = r_o_opw;
        n_o_pc   = r_o_pc;
        n_o_val  = r_o_val;
        n_o_rval = r_o_rval;
        n_o_run  = r_o_run;
        n_o_zf   = r_o_zf;
        n_o_cf   = r_o_cf;
        mem_we   = 1'b0;
        mem_wa   = r_clr;
        mem_wd   = 32'd0;
        mem_ra   = r_addr[AW-1:0];
        rf_idx   = 3'd0;
        div_req  = '{start: 1'b0, dividend: r_a, divisor: r_b};

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == LastIdx) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd    = t_cmd'(i_cmd.command);
                    n_addr   = 32'(i_cmd.address);
                    n_data   = $unsigned(i_cmd.data);
                    n_sel    = i_cmd.reg_select;
                    n_status = STS_DONE;
                    n_opw    = 32'd0;
                    n_val    = 32'd0;
                    n_rval   = 32'd0;
                    n_state  = ST_DONE;
                    case (t_cmd'(i_cmd.command))
                        CMD_WRITE: begin
                            mem_wa = n_addr[AW-1:0];
                            mem_wd = n_data;
                            mem_we = (n_addr < MemSize);
                        end
                        CMD_START: begin
                            n_pc  = 32'd0;
                            n_run = 1'b1;
                        end
                        CMD_STEP: begin
                            if (!r_run) begin
                                n_status = STS_NOT_RUN;
                            end else if (r_pc >= MemSize) begin
                                n_run    = 1'b0;
                                n_status = STS_PC_RANGE;
                            end else begin
                                n_k     = 2'd0;
                                n_state = ST_FETCH;
                            end
                        end
                        default: begin
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                mem_ra  = r_addr[AW-1:0];
                n_state = ST_RDCAP;
            end
            ST_RDCAP: begin
                rf_idx  = reg_index(32'(r_sel));
                n_val   = (r_addr < MemSize) ? r_rdata : 32'd0;
                n_rval  = rf_rd;
                n_state = ST_DONE;
            end
            ST_FETCH: begin
                mem_ra  = fetch_addr[AW-1:0];
                n_state = ST_FCAP;
            end
            ST_FCAP: begin
                n_ops[r_k] = (fetch_addr < MemSize) ? r_rdata : 32'd0;
                if (r_k == 2'd0) begin
                    n_opw = r_rdata;
                end
                if (r_k == 2'd3) begin
                    n_state = ST_RDA;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_FETCH;
                end
            end
            ST_RDA: begin
                rf_idx  = r1;
                n_a     = rf_rd;
                n_state = ST_RDB;
            end
            ST_RDB: begin
                rf_idx  = r2;
                n_b     = rf_rd;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_status = STS_EXECUTED;
                n_state  = ST_DONE;
                case (r_ops[0])
                    OP_LDI: begin
                        n_rf[r1] = r_ops[2];
                        n_pc     = r_pc + 32'd3;
                    end
                    OP_ST: begin
                        mem_wa = r_ops[2][AW-1:0];
                        mem_wd = r_a;
                        mem_we = (r_ops[2] < MemSize);
                        n_pc   = r_pc + 32'd3;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
                        n_state = ST_ALU;
                    end
                    OP_DIV: begin
                        if (r_b == 32'd0) begin
                            n_run    = 1'b0;
                            n_status = STS_DIV_ZERO;
                            n_pc     = r_pc + 32'd3;
                        end else begin
                            div_req.start = 1'b1;
                            n_state       = ST_DIV;
                        end
                    end
                    OP_JMP: begin
                        n_pc = r_ops[1];
                    end
                    OP_JEQ, OP_JNE: begin
                        if ((r_a == r_b) == (r_ops[0] == OP_JEQ)) begin
                            n_pc = r_ops[3];
                        end else begin
                            n_pc = r_pc + 32'd4;
                        end
                    end
                    OP_PRT: begin
                        n_val = r_a;
                        n_pc  = r_pc + 32'd2;
                    end
                    OP_HALT: begin
                        n_run    = 1'b0;
                        n_status = STS_HALTED;
                    end
                    default: begin
                        n_run    = 1'b0;
                        n_status = STS_BAD_OP;
                    end
                endcase
            end
            ST_ALU: begin
                n_res   = alu_out;
                n_state = ST_WB;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_res   = div_q;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (r_ops[0] != OP_CMP) begin
                    n_rf[r1] = r_res;
                end
                n_zf    = (r_res == 32'd0);
                n_cf    = r_res[31] ? (r_res < CarryLo) : (r_res > CarryHi);
                n_pc    = r_pc + 32'd3;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_out_valid = 1'b1;
                n_o_status  = r_status;
                n_o_opw     = r_opw;
                n_o_pc      = r_pc;
                n_o_run     = r_run;
                n_o_zf      = r_zf;
                n_o_cf      = r_cf;
                n_o_val     = r_val;
                n_o_rval    = r_rval;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= 32'd0;
            r_run       <= 1'b0;
            r_zf        <= 1'b0;
            r_cf        <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= 2'd0;
            for (int i = 0; i < NumRegs; i++) begin
                r_rf[i] <= (i == NumRegs - 1) ? (MemSize - 32'd1) : 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_run       <= n_run;
            r_zf        <= n_zf;
            r_cf        <= n_cf;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_rf        <= n_rf;
        end
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_sel      <= n_sel;
        r_ops      <= n_ops;
        r_a        <= n_a;
        r_b        <= n_b;
        r_res      <= n_res;
        r_status   <= n_status;
        r_opw      <= n_opw;
        r_val      <= n_val;
        r_rval     <= n_rval;
        r_o_status <= n_o_status;
        r_o_opw    <= n_o_opw;
        r_o_pc     <= n_o_pc;
        r_o_run    <= n_o_run;
        r_o_zf     <= n_o_zf;
        r_o_cf     <= n_o_cf;
        r_o_val    <= n_o_val;
        r_o_rval   <= n_o_rval;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_o_status;
    assign o_res.opcode       = $signed(r_o_opw);
    assign o_res.prog_counter = $signed(r_o_pc);
    assign o_res.is_running   = r_o_run;
    assign o_res.zero_flag    = r_o_zf;
    assign o_res.carry_flag   = r_o_cf;
    assign o_res.value        = $signed(r_o_val);
    assign o_res.reg_value    = $signed(r_o_rval);

    // a transfer in is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_cmd.ready)
        else $error("ready high right after an accepted command");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide wait");

    // no memory write happens during a step fetch
    a_no_write_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH || r_state == ST_FCAP) |-> !mem_we)
        else $error("memory write during instruction fetch");

endmodule

### rtl/trm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module trm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trm_pkg::t_div_req   i_req,
    output logic                o_done,
    output logic [31:0]         o_quotient
);
    import trm_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [32:0] rem_sh, diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        rem_sh = {r_rem[31:0], r_quo[31]};
        diff   = rem_sh - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 33'd0;
            n_quo  = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            n_den  = i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            n_neg  = i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                n_rem = diff;
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

### tb/toy_register_machine_core_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_register_machine_core_top_test
// Checks the register machine core against a cycle-free software image of
// its memory, registers, PC and flags: programs are written, started and
// stepped with random idling on both channels, and every result is compared
// field by field.
// ----------------------------------------------------------------------------
module toy_register_machine_core_top_test;
    import trm_pkg::*;

    localparam int MemWords = 1024;
    localparam int CycleLimit = 2000000;

    // one expected result
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] opcode;
        logic [31:0] prog_counter;
        logic        is_running;
        logic        zero_flag;
        logic        carry_flag;
        logic [31:0] value;
        logic [31:0] reg_value;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    trm_in_if  cmd_ch ();
    trm_out_if res_ch ();

    toy_register_machine_core_top #(.MEM_WORDS(MemWords)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // machine image kept by the testbench
    logic [31:0] mem_img [MemWords];
    logic [31:0] regs_img [NumRegs];
    logic [31:0] pc_img;
    logic        run_img, zero_img, carry_img;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      step_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_off = 1'b0;
    int      hold_cycles = 0;
    int      status_seen [8];

    function automatic logic [31:0] mem_word(input logic [31:0] addr);
        return (addr < MemWords) ? mem_img[addr] : 32'd0;
    endfunction

    function automatic int sel_reg(input logic [31:0] code);
        return (code < NumRegs) ? int'(code) : 0;
    endfunction

    function automatic void flags_from(input logic [31:0] r);
        zero_img  = (r == 32'd0);
        carry_img = r[31] ? (r < CarryLo) : (r > CarryHi);
    endfunction

    // signed division truncating toward zero, wrapping at 32 bits
    function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // one instruction of the machine image
    function automatic void run_instruction(inout t_result r);
        logic [31:0] op, a1, a2, a3, res;
        int r1, r2;
        bit eq;
        if (!run_img) begin
            r.status = STS_NOT_RUN;
            return;
        end
        if (pc_img >= MemWords) begin
            run_img  = 1'b0;
            r.status = STS_PC_RANGE;
            return;
        end
        op = mem_img[pc_img];
        r.opcode = op;
        a1 = mem_word(pc_img + 1);
        a2 = mem_word(pc_img + 2);
        a3 = mem_word(pc_img + 3);
        r1 = sel_reg(a1);
        r2 = sel_reg(a2);
        r.status = STS_EXECUTED;
        case (op)
            OP_LDI: begin
                regs_img[r1] = a2;
                pc_img += 3;
            end
            OP_ST: begin
                if (a2 < MemWords) mem_img[a2] = regs_img[r1];
                pc_img += 3;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
                if (op == OP_ADD) res = regs_img[r1] + regs_img[r2];
                else if (op == OP_MUL) res = regs_img[r1] * regs_img[r2];
                else res = regs_img[r1] - regs_img[r2];
                if (op != OP_CMP) regs_img[r1] = res;
                flags_from(res);
                pc_img += 3;
            end
            OP_DIV: begin
                pc_img += 3;
                if (regs_img[r2] == 0) begin
                    run_img  = 1'b0;
                    r.status = STS_DIV_ZERO;
                end else begin
                    res = quotient(regs_img[r1], regs_img[r2]);
                    regs_img[r1] = res;
                    flags_from(res);
                end
            end
            OP_JMP: pc_img = a1;
            OP_JEQ, OP_JNE: begin
                eq = regs_img[r1] == regs_img[r2];
                pc_img = ((op == OP_JEQ) ? eq : !eq) ? a3 : pc_img + 4;
            end
            OP_PRT: begin
                r.value = regs_img[r1];
                pc_img += 2;
            end
            OP_HALT: begin
                run_img  = 1'b0;
                r.status = STS_HALTED;
            end
            default: begin
                run_img  = 1'b0;
                r.status = STS_BAD_OP;
            end
        endcase
    endfunction

    function automatic t_result machine_result(input t_cmd cmd, input logic [9:0] addr,
                                               input logic [31:0] data,
                                               input logic [2:0] sel);
        t_result r;
        r = '0;
        r.status = STS_DONE;
        case (cmd)
            CMD_WRITE: if (addr < MemWords) mem_img[addr] = data;
            CMD_START: begin
                pc_img  = 32'd0;
                run_img = 1'b1;
            end
            CMD_STEP: run_instruction(r);
            default: begin
                r.value     = mem_word(addr);
                r.reg_value = regs_img[sel_reg(sel)];
            end
        endcase
        r.prog_counter = pc_img;
        r.is_running   = run_img;
        r.zero_flag    = zero_img;
        r.carry_flag   = carry_img;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("result %0d: %s got %h expected %h", result_count, what, got, want);
    endtask

    // sends one command; predicts its result at the transfer
    task automatic send_command(input t_cmd cmd, input logic [9:0] addr = '0,
                                input logic [31:0] data = '0, input logic [2:0] sel = '0);
        // bus goes idle after a transfer; the core is busy then anyway
        @(posedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge i_clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.address    <= addr;
        cmd_ch.data       <= data;
        cmd_ch.reg_select <= sel;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_results.push_back(machine_result(cmd, addr, data, sel));
        if (cmd == CMD_STEP) step_count++;
        cmd_ch.valid <= 1'b0;
    endtask

    task automatic write_words(input int base, input logic [31:0] w [$]);
        foreach (w[i]) send_command(CMD_WRITE, 10'(base + i), w[i]);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: ready with random idling and a long hold-off on request
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles + 1;
        end else begin
            res_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("result %0d arrived with nothing expected", result_count);
            end else begin
                want = pending_results.pop_front();
                status_seen[res_ch.status]++;
                if (res_ch.status != want.status)
                    report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                if (res_ch.opcode != want.opcode)
                    report_mismatch("opcode", res_ch.opcode, want.opcode);
                if (res_ch.prog_counter != want.prog_counter)
                    report_mismatch("prog_counter", res_ch.prog_counter, want.prog_counter);
                if (res_ch.is_running != want.is_running)
                    report_mismatch("is_running", 32'(res_ch.is_running),
                                    32'(want.is_running));
                if (res_ch.zero_flag != want.zero_flag)
                    report_mismatch("zero_flag", 32'(res_ch.zero_flag), 32'(want.zero_flag));
                if (res_ch.carry_flag != want.carry_flag)
                    report_mismatch("carry_flag", 32'(res_ch.carry_flag),
                                    32'(want.carry_flag));
                if (res_ch.value != want.value)
                    report_mismatch("value", res_ch.value, want.value);
                if (res_ch.reg_value != want.reg_value)
                    report_mismatch("reg_value", res_ch.reg_value, want.reg_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(70000)) - 35000);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset contents, extremes of the fields, step while stopped
    task automatic test_directed_basics();
        send_command(CMD_READ, 10'd0, '0, 3'd4);
        send_command(CMD_READ, 10'd1023, '0, 3'd7);
        send_command(CMD_STEP);
        send_command(CMD_WRITE, 10'd1023, 32'h8000_0000);
        send_command(CMD_WRITE, 10'd1022, 32'h7FFF_FFFF);
        send_command(CMD_READ, 10'd1023, 32'hFFFF_FFFF, 3'd5);
        send_command(CMD_READ, 10'd1022, '0, 3'd3);
    endtask

    // most opcodes, divide extremes, operands past memory
    task automatic test_directed_program();
        logic [31:0] prog [$];
        prog = '{OP_LDI, 1, 32'h8000_0000,     // r1 = most negative
                 OP_LDI, 2, 32'hFFFF_FFFF,     // r2 = -1
                 OP_DIV, 1, 2,                 // wraps to most negative
                 OP_MUL, 1, 2,
                 OP_ADD, 1, 2,
                 OP_SUB, 2, 2,                 // r2 = 0, zero flag
                 OP_CMP, 1, 7,
                 OP_ST,  1, 1000,
                 OP_ST,  1, 32'h0000_1000,     // store beyond memory, ignored
                 OP_PRT, 4,
                 OP_JEQ, 2, 0, 40,
                 OP_JNE, 2, 0, 0,
                 OP_JNE, 1, 2, 45,
                 OP_JMP, 47,
                 OP_DIV, 1, 2};                // divide by zero
        write_words(0, prog);
        send_command(CMD_START);
        repeat (16) send_command(CMD_STEP);
        send_command(CMD_READ, 10'd1000, '0, 3'd1);
        // halt, unknown opcode, PC out of range, operands past memory
        write_words(0, '{OP_HALT});
        send_command(CMD_START);
        send_command(CMD_STEP);
        write_words(0, '{32'd12});
        send_command(CMD_START);
        send_command(CMD_STEP);
        write_words(0, '{OP_JMP, 32'hFFFF_FFF0});
        write_words(1021, '{OP_JMP, 1022, OP_LDI});
        send_command(CMD_START);
        repeat (3) send_command(CMD_STEP);
        write_words(0, '{OP_JMP, 1021});
        send_command(CMD_START);
        repeat (3) send_command(CMD_STEP);
    endtask

    // random programs in a small window, stepped; some noise commands mixed in
    task automatic test_random_programs(input int items);
        int sent, base, len, op;
        logic [31:0] w;
        sent = 0;
        while (sent < items) begin
            len = $urandom_range(6, 24);
            for (int i = 0; i < len; i++) begin
                op = $urandom_range(99);
                if (op < 88) w = $urandom_range(11);
                else if (op < 94) w = $urandom_range(6, 0);
                else w = rand_word();
                // operand words: mostly small register codes or nearby targets
                send_command(CMD_WRITE, 10'(i * 4), w);
                for (int k = 1; k < 4; k++) begin
                    op = $urandom_range(9);
                    w = (op < 5) ? $urandom_range(7)
                      : (op < 8) ? 32'(4 * $urandom_range(len)) : rand_word();
                    send_command(CMD_WRITE, 10'(i * 4 + k), w);
                end
                sent += 4;
            end
            send_command(CMD_START);
            repeat ($urandom_range(4, 30)) begin
                op = $urandom_range(19);
                if (op == 0) send_command(CMD_READ, 10'($urandom), '0, 3'($urandom));
                else if (op == 1) send_command(CMD_WRITE, 10'($urandom), rand_word());
                else send_command(CMD_STEP);
                sent++;
            end
            base = $urandom_range(1023);
            send_command(CMD_READ, 10'(base), '0, 3'($urandom));
            sent++;
        end
    endtask

    // receiver holds off while commands keep coming, then the sender drains
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                wait (hold_cycles >= 400);
                hold_off = 1'b0;
            end
            repeat (6) send_command(CMD_READ, 10'($urandom), '0, 3'($urandom));
        join
        drain_results();
    endtask

    initial begin
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_WRITE;
        cmd_ch.address    <= '0;
        cmd_ch.data       <= '0;
        cmd_ch.reg_select <= '0;
        foreach (mem_img[i]) mem_img[i] = '0;
        foreach (regs_img[i]) regs_img[i] = '0;
        regs_img[4] = MemWords - 1;
        pc_img = '0;
        run_img = 1'b0;
        zero_img = 1'b0;
        carry_img = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_directed_program();
        test_backpressure();
        send_idle_pct = 33;
        recv_idle_pct = 62;
        test_random_programs(450);
        drain_results();
        send_idle_pct = 62;
        recv_idle_pct = 33;
        test_random_programs(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_programs(400);

        drain_results();
        repeat (100) @(posedge i_clk);
        $display("%0d results checked, %0d of them steps", result_count, step_count);
        $display("statuses 0..6 seen %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
